// ----- hdl/projected_pair_distance_histogram_macros.svh -----
// Assertion macros shared by the pair histogram RTL.
`ifndef PROJECTED_PAIR_DISTANCE_HISTOGRAM_MACROS_SVH
`define PROJECTED_PAIR_DISTANCE_HISTOGRAM_MACROS_SVH
// Same-cycle implication, checked outside reset.
`define PPH_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication, checked outside reset.
`define PPH_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);
`endif

// ----- hdl/pphist_pkg.sv -----
// Shared constants for the projected pair distance histogram.
`default_nettype none
package pphist_pkg;
  localparam int DEF_MAX_RP_EDGES = 32;
  localparam int DEF_MAX_PI_BINS  = 32;
  localparam int SQ_IN_W  = 63;
  localparam int SQ_OUT_W = 32;
  localparam logic [1:0] OP_LOAD_EDGE = 2'd0;
  localparam logic [1:0] OP_COUNT     = 2'd1;
  localparam logic [1:0] OP_READ      = 2'd2;
  localparam logic [1:0] CFG_NUM_RP_EDGES = 2'd0;
  localparam logic [1:0] CFG_NUM_PI_BINS  = 2'd1;
  localparam logic [1:0] CFG_PI_MAX       = 2'd2;
  localparam logic [1:0] CFG_INV_PI_WIDTH = 2'd3;
endpackage
`default_nettype wire

// ----- hdl/pphist_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module pphist_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// ----- hdl/pphist_sqrt.sv -----
// Iterative integer square root, two radicand bits per cycle.
`default_nettype none
module pphist_sqrt
  import pphist_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                start,
  input  wire logic [SQ_IN_W-1:0]  radicand,
  output logic                     done,
  output logic      [SQ_OUT_W-1:0] root
);
  localparam int RW = 2 * SQ_OUT_W;
  localparam int MW = SQ_OUT_W + 3;
  localparam int CNW = $clog2(SQ_OUT_W);

  logic [RW-1:0]  rad;
  logic [MW-1:0]  rem;
  logic [CNW-1:0] cnt;
  logic           busy;
  logic [MW+1:0]  rem_sh;
  logic [MW+1:0]  trial;

  assign rem_sh = {rem, rad[RW-1 -: 2]};
  assign trial  = {3'b000, root, 2'b01};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        rad  <= RW'(radicand);
        rem  <= '0;
        root <= '0;
        cnt  <= '0;
        busy <= 1'b1;
      end else if (busy) begin
        if (rem_sh >= trial) begin
          rem  <= MW'(rem_sh - trial);
          root <= {root[SQ_OUT_W-2:0], 1'b1};
        end else begin
          rem  <= MW'(rem_sh);
          root <= {root[SQ_OUT_W-2:0], 1'b0};
        end
        rad <= {rad[RW-3:0], 2'b00};
        cnt <= cnt + 1'b1;
        if (cnt == CNW'(SQ_OUT_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
endmodule
`default_nettype wire

// ----- hdl/projected_pair_distance_histogram.sv -----
// Top level of the projected pair distance histogram.
`default_nettype none
`include "projected_pair_distance_histogram_macros.svh"
// One item at a time. After reset every entry of the bin memory is cleared
// (MAX_RP_EDGES*(MAX_PI_BINS+1) entries, 1056 by default) with in_stall high.
// An edge load, an unused op or a pair with no edges in use is taken in IDLE
// alone; a bin read passes RDW and OUT and waits in OUT on out_stall.
// A counted pair passes MUL, SUM and CHK, then the edge search walks the edge
// memory one entry per step from the top, then a 32-step square root unit runs,
// then the bin memory is read, modified and written back. Dropped pairs leave
// from CHK.
module projected_pair_distance_histogram
  import pphist_pkg::*;
#(
  parameter int MAX_RP_EDGES = DEF_MAX_RP_EDGES,
  parameter int MAX_PI_BINS  = DEF_MAX_PI_BINS
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [31:0] cfg_data,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [1:0]  op,
  input  wire logic [10:0] slot,
  input  wire logic [62:0] edge_squared,
  input  wire logic [30:0] first_x,
  input  wire logic [30:0] first_y,
  input  wire logic [30:0] first_z,
  input  wire logic [30:0] second_x,
  input  wire logic [30:0] second_y,
  input  wire logic [30:0] second_z,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [31:0]      bin_count,
  output logic [62:0]      bin_distance_sum
);
  localparam int BIN_DEPTH = MAX_RP_EDGES * (MAX_PI_BINS + 1);
  localparam int BAW = $clog2(BIN_DEPTH);
  localparam int EW  = $clog2(MAX_RP_EDGES);
  localparam int NEW = $clog2(MAX_RP_EDGES + 1);
  localparam int CW  = (NEW > 6) ? NEW : 6;
  localparam int NPW = $clog2(MAX_PI_BINS + 1);
  localparam int PW  = (NPW > 6) ? NPW : 6;
  localparam int BW  = 95;

  localparam logic [3:0] S_CLEAR = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_MUL   = 4'd2;
  localparam logic [3:0] S_SUM   = 4'd3;
  localparam logic [3:0] S_CHK   = 4'd4;
  localparam logic [3:0] S_SCAN  = 4'd5;
  localparam logic [3:0] S_SQRT  = 4'd6;
  localparam logic [3:0] S_RDW   = 4'd7;
  localparam logic [3:0] S_UPD   = 4'd8;
  localparam logic [3:0] S_OUT   = 4'd9;

  logic [5:0]  num_rp_edges;
  logic [5:0]  num_pi_bins;
  logic [30:0] pi_max;
  logic [31:0] inv_pi_width;

  logic [3:0]     state;
  logic [BAW-1:0] clr_cnt;
  logic [30:0]    dx, dy, dz;
  logic [61:0]    sq_x, sq_y;
  logic [62:0]    prod;
  logic [62:0]    r2;
  logic [62:0]    edge_hi;
  logic [PW-1:0]  pib;
  logic [EW-1:0]  k;
  logic [31:0]    root_r;
  logic [BAW-1:0] bin_addr;
  logic           rd_oob;
  logic           is_read;

  logic [CW-1:0]  ne_c, ne_m1, ne_m2;
  logic [PW-1:0]  np_c;
  logic [30:0]    pib_raw;
  logic           in_accept;
  logic [EW-1:0]  edge_raddr;
  logic [62:0]    edge_q;
  logic           edge_we;
  logic           bin_we;
  logic [BAW-1:0] bin_waddr;
  logic [BW-1:0]  bin_wdata, bin_q;
  logic           sq_start, sq_done;
  logic [31:0]    sq_root;
  logic [63:0]    sum_wide;
  logic [62:0]    new_sum;
  logic [31:0]    new_count;
  logic           found;
  logic           out_free;

  assign ne_c  = (CW'(num_rp_edges) > CW'(MAX_RP_EDGES)) ? CW'(MAX_RP_EDGES)
                                                         : CW'(num_rp_edges);
  assign ne_m1 = ne_c - CW'(1);
  assign ne_m2 = ne_c - CW'(2);
  assign np_c  = (PW'(num_pi_bins) > PW'(MAX_PI_BINS)) ? PW'(MAX_PI_BINS)
                                                       : PW'(num_pi_bins);
  assign pib_raw   = prod[62:32];
  assign in_stall  = (state != S_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign out_free  = !out_valid || !out_stall;
  assign found     = (state == S_SCAN) && ((k == '0) || (r2 >= edge_q));
  assign sq_start  = found;
  assign edge_we   = in_accept && (op == OP_LOAD_EDGE) && (32'(slot) < 32'(MAX_RP_EDGES));

  always_comb begin
    case (state)
      S_MUL:   edge_raddr = ne_m1[EW-1:0];
      S_CHK:   edge_raddr = ne_m2[EW-1:0];
      S_SCAN:  edge_raddr = k - 1'b1;
      default: edge_raddr = '0;
    endcase
  end

  assign sum_wide  = {1'b0, bin_q[94:32]} + 64'(root_r);
  assign new_sum   = sum_wide[63] ? '1 : sum_wide[62:0];
  assign new_count = (bin_q[31:0] == '1) ? bin_q[31:0] : bin_q[31:0] + 32'd1;
  assign bin_we    = (state == S_CLEAR) || (state == S_UPD);
  assign bin_waddr = (state == S_CLEAR) ? clr_cnt : bin_addr;
  assign bin_wdata = (state == S_CLEAR) ? '0 : {new_sum, new_count};

  pphist_ram #(.WIDTH(63), .DEPTH(MAX_RP_EDGES)) u_edge_ram (
    .clk   (clk),
    .we    (edge_we),
    .waddr (slot[EW-1:0]),
    .wdata (edge_squared),
    .raddr (edge_raddr),
    .rdata (edge_q)
  );

  pphist_ram #(.WIDTH(BW), .DEPTH(BIN_DEPTH)) u_bin_ram (
    .clk   (clk),
    .we    (bin_we),
    .waddr (bin_waddr),
    .wdata (bin_wdata),
    .raddr (bin_addr),
    .rdata (bin_q)
  );

  pphist_sqrt u_sqrt (
    .clk      (clk),
    .rst      (rst),
    .start    (sq_start),
    .radicand (r2),
    .done     (sq_done),
    .root     (sq_root)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      num_rp_edges <= 6'd32;
      num_pi_bins  <= 6'd32;
      pi_max       <= '1;
      inv_pi_width <= 32'd65536;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_NUM_RP_EDGES: num_rp_edges <= cfg_data[5:0];
        CFG_NUM_PI_BINS:  num_pi_bins  <= cfg_data[5:0];
        CFG_PI_MAX:       pi_max       <= cfg_data[30:0];
        CFG_INV_PI_WIDTH: inv_pi_width <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_cnt   <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && !out_stall && (state != S_OUT)) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_CLEAR: begin
          clr_cnt <= clr_cnt + 1'b1;
          if (clr_cnt == BAW'(BIN_DEPTH - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_accept) begin
            dx <= (first_x >= second_x) ? first_x - second_x : second_x - first_x;
            dy <= (first_y >= second_y) ? first_y - second_y : second_y - first_y;
            dz <= (first_z >= second_z) ? first_z - second_z : second_z - first_z;
            rd_oob   <= !(32'(slot) < 32'(BIN_DEPTH));
            bin_addr <= BAW'(slot);
            is_read  <= (op == OP_READ);
            if (op == OP_COUNT && ne_c != '0) begin
              state <= S_MUL;
            end else if (op == OP_READ) begin
              state <= S_RDW;
            end
          end
        end
        S_MUL: begin
          sq_x  <= dx * dx;
          sq_y  <= dy * dy;
          prod  <= dz * inv_pi_width;
          state <= S_SUM;
        end
        S_SUM: begin
          edge_hi <= edge_q;
          r2      <= 63'(sq_x) + 63'(sq_y);
          pib     <= (pib_raw > 31'(np_c)) ? np_c : pib_raw[PW-1:0];
          state   <= S_CHK;
        end
        S_CHK: begin
          // edge_q holds the first edge here
          if (r2 >= edge_hi || r2 < edge_q || dz >= pi_max) begin
            state <= S_IDLE;
          end else begin
            k     <= ne_m2[EW-1:0];
            state <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (found) begin
            state <= S_SQRT;
          end else begin
            k <= k - 1'b1;
          end
        end
        S_SQRT: begin
          bin_addr <= BAW'(BAW'(k) * BAW'(np_c + PW'(1)) + BAW'(pib));
          if (sq_done) begin
            root_r <= sq_root;
            state  <= S_RDW;
          end
        end
        S_RDW: begin
          state <= is_read ? S_OUT : S_UPD;
        end
        S_UPD: begin
          state <= S_IDLE;
        end
        S_OUT: begin
          // hold the read address until the output register frees up
          if (out_free) begin
            out_valid        <= 1'b1;
            bin_count        <= rd_oob ? '0 : bin_q[31:0];
            bin_distance_sum <= rd_oob ? '0 : bin_q[94:32];
            state            <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `PPH_ASSERT_NOW(a_no_write_on_read, state == S_OUT, !bin_we,
                  "bin memory written while a read is pending")
  `PPH_ASSERT_NOW(a_sqrt_done_state, sq_done, state == S_SQRT,
                  "square root finished outside its wait state")
  `PPH_ASSERT_NOW(a_scan_in_range, state == S_SCAN, CW'(k) < ne_m1,
                  "edge search index beyond edges in use")
  `PPH_ASSERT_NEXT(a_update_to_idle, state == S_UPD, state == S_IDLE,
                   "update did not return to idle")
endmodule
`default_nettype wire

// ----- verif/testbench.sv -----
// Self-checking testbench for the projected pair distance histogram.
`default_nettype none
module testbench
  import pphist_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int EDGES = DEF_MAX_RP_EDGES;
  localparam int PIBINS = DEF_MAX_PI_BINS;
  localparam int BINS = EDGES * (PIBINS + 1);
  localparam logic [1:0] OP_NONE = 2'd3;
  localparam longint unsigned MAX31 = 64'h7FFF_FFFF;
  localparam longint unsigned MAX63 = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam int QUIET_LIMIT = 20000;
  localparam int SETTLE = 150;

  typedef struct {
    logic [1:0]  op;
    logic [10:0] slot;
    logic [62:0] edge_sq;
    logic [30:0] fx, fy, fz, sx, sy, sz;
  } pair_beat_t;

  typedef struct {
    logic [31:0] cnt;
    logic [62:0] dsum;
  } bin_reading_t;

  typedef struct {
    pair_beat_t  beat;
    bit          typed;
    logic [31:0] cnt;
    logic [62:0] dsum;
  } directed_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = '0;
  logic [31:0] cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  op = '0;
  logic [10:0] slot = '0;
  logic [62:0] edge_squared = '0;
  logic [30:0] first_x = '0, first_y = '0, first_z = '0;
  logic [30:0] second_x = '0, second_y = '0, second_z = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [31:0] bin_count;
  logic [62:0] bin_distance_sum;

  projected_pair_distance_histogram dut (.*);

  always #10 clk = ~clk;

  // histogram shadow state
  logic [62:0] edge_sq_shadow [EDGES];
  logic [31:0] count_shadow [BINS];
  logic [62:0] dsum_shadow [BINS];
  logic [5:0]  n_edges_reg;
  logic [5:0]  n_pi_reg;
  logic [30:0] pi_cut_reg;
  logic [31:0] inv_width_reg;

  bin_reading_t pending_reads[$];
  int mismatch_count = 0;
  int items_sent = 0;
  int reads_checked = 0;
  int pairs_binned = 0;
  int last_bin = 0;
  bit idle_on = 1'b1;
  bit hold_req = 1'b0;
  int hold_cycles = 0;
  int quiet = 0;

  function automatic longint unsigned floor_sqrt(longint unsigned v);
    longint unsigned root, trial;
    root = 0;
    for (int b = 31; b >= 0; b--) begin
      trial = root | (64'd1 << b);
      if (trial * trial <= v) root = trial;
    end
    return root;
  endfunction

  function automatic longint unsigned dist1(logic [30:0] a, logic [30:0] b);
    return (a >= b) ? longint'(a - b) : longint'(b - a);
  endfunction

  task automatic histogram_predict(input pair_beat_t b, input bit typed,
                                   input bin_reading_t typed_val);
    longint unsigned ne, np, dx, dy, dz, r2, pib, k, idx, r;
    bin_reading_t rd;
    case (b.op)
      OP_LOAD_EDGE: if (b.slot < EDGES) edge_sq_shadow[b.slot] = b.edge_sq;
      OP_COUNT: begin
        ne = (n_edges_reg > EDGES) ? EDGES : n_edges_reg;
        np = (n_pi_reg > PIBINS) ? PIBINS : n_pi_reg;
        dx = dist1(b.fx, b.sx);
        dy = dist1(b.fy, b.sy);
        dz = dist1(b.fz, b.sz);
        r2 = dx * dx + dy * dy;
        if (ne != 0 && r2 < edge_sq_shadow[ne - 1] && r2 >= edge_sq_shadow[0]
            && dz < pi_cut_reg) begin
          pib = (dz * inv_width_reg) >> 32;
          if (pib > np) pib = np;
          k = ne - 1;
          while (k > 0 && r2 < edge_sq_shadow[k]) k--;
          idx = k * (np + 1) + pib;
          if (idx < BINS) begin
            r = floor_sqrt(r2);
            if (count_shadow[idx] != 32'hFFFF_FFFF) count_shadow[idx]++;
            if (dsum_shadow[idx] > MAX63 - r) dsum_shadow[idx] = 63'(MAX63);
            else dsum_shadow[idx] = 63'(dsum_shadow[idx] + r);
            last_bin = int'(idx);
            pairs_binned++;
          end
        end
      end
      OP_READ: begin
        if (typed) rd = typed_val;
        else if (b.slot < BINS) begin
          rd.cnt = count_shadow[b.slot];
          rd.dsum = dsum_shadow[b.slot];
        end else begin
          rd.cnt = '0;
          rd.dsum = '0;
        end
        pending_reads.push_back(rd);
      end
      default: ;
    endcase
  endtask

  task automatic send_beat(input pair_beat_t b, input bit typed = 1'b0,
                           input logic [31:0] cnt = '0, input logic [62:0] dsum = '0);
    bin_reading_t tv;
    if (idle_on)
      while ($urandom_range(0, 99) < 24) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end
    in_valid <= 1'b1;
    op <= b.op;
    slot <= b.slot;
    edge_squared <= b.edge_sq;
    first_x <= b.fx;
    first_y <= b.fy;
    first_z <= b.fz;
    second_x <= b.sx;
    second_y <= b.sy;
    second_z <= b.sz;
    do @(posedge clk); while (in_stall);
    tv.cnt = cnt;
    tv.dsum = dsum;
    histogram_predict(b, typed, tv);
    items_sent++;
  endtask

  // drop the valid, let every read come back, then give queued work time to drain
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_reads.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // the caller drops cfg_we after the last write of a burst
  task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    case (idx)
      CFG_NUM_RP_EDGES: n_edges_reg = val[5:0];
      CFG_NUM_PI_BINS:  n_pi_reg = val[5:0];
      CFG_PI_MAX:       pi_cut_reg = val[30:0];
      CFG_INV_PI_WIDTH: inv_width_reg = val;
      default: ;
    endcase
  endtask

  function automatic logic [30:0] partner(logic [30:0] base, longint unsigned off);
    return (base + off <= MAX31) ? 31'(base + off) : 31'(base - off);
  endfunction

  function automatic logic [62:0] rand63();
    return 63'({$urandom, $urandom});
  endfunction

  function automatic pair_beat_t blank_beat(logic [1:0] o);
    pair_beat_t b;
    b.op = o;
    b.slot = '0;
    b.edge_sq = '0;
    b.fx = '0; b.fy = '0; b.fz = '0;
    b.sx = '0; b.sy = '0; b.sz = '0;
    return b;
  endfunction

  task automatic load_edges(input longint unsigned step, input bit sorted);
    pair_beat_t b;
    longint unsigned rad;
    for (int i = 0; i < EDGES; i++) begin
      b = blank_beat(OP_LOAD_EDGE);
      b.slot = 11'(i);
      rad = sorted ? i * step : $urandom_range(0, 31) * step;
      b.edge_sq = 63'(rad * rad);
      if (!sorted && i == EDGES - 1) b.edge_sq = {1'b1, 62'(rand63())};
      send_beat(b);
    end
  endtask

  task automatic random_beat(input longint unsigned step, input longint unsigned zspan);
    pair_beat_t b;
    int pick;
    b = blank_beat(OP_COUNT);
    pick = $urandom_range(0, 99);
    if (pick < 60) begin
      b.fx = 31'($urandom); b.fy = 31'($urandom); b.fz = 31'($urandom);
      if ($urandom_range(0, 9) == 0) begin
        b.sx = 31'($urandom); b.sy = 31'($urandom); b.sz = 31'($urandom);
      end else begin
        b.sx = partner(b.fx, $urandom_range(0, 32'(32 * step)));
        b.sy = partner(b.fy, $urandom_range(0, 32'(32 * step)));
        b.sz = partner(b.fz, $urandom_range(0, 32'(zspan)));
      end
    end else if (pick < 85) begin
      b.op = OP_READ;
      case ($urandom_range(0, 9))
        0:       b.slot = 11'($urandom_range(0, 2047));
        1, 2, 3, 4: b.slot = 11'($urandom_range(0, BINS - 1));
        default: b.slot = 11'(last_bin);
      endcase
    end else if (pick < 95) begin
      b.op = OP_LOAD_EDGE;
      b.slot = 11'($urandom_range(0, 40));
      b.edge_sq = ($urandom_range(0, 3) == 0) ? rand63()
                  : 63'(($urandom_range(0, 31) * step) * ($urandom_range(0, 31) * step));
    end else begin
      b.op = OP_NONE;
      b.slot = 11'($urandom);
      b.edge_sq = rand63();
      b.fx = 31'($urandom); b.sz = 31'($urandom);
    end
    send_beat(b);
  endtask

  task automatic run_phase(input int ne, input int np, input longint unsigned pim,
                           input longint unsigned inv, input int step_log,
                           input int zspan_log, input bit sorted, input bit idle,
                           input int n, input bit squeeze);
    longint unsigned step;
    step = 64'd1 << step_log;
    wait_drained();
    idle_on = idle;
    write_reg(CFG_NUM_RP_EDGES, 32'(ne));
    write_reg(CFG_NUM_PI_BINS, 32'(np));
    write_reg(CFG_PI_MAX, 32'(pim));
    write_reg(CFG_INV_PI_WIDTH, 32'(inv));
    cfg_we <= 1'b0;
    load_edges(step, sorted);
    for (int i = 0; i < n; i++) begin
      if (squeeze && i == n / 3) hold_req = 1'b1;
      if (squeeze && i == 2 * n / 3) wait_drained();
      random_beat(step, 64'd1 << zspan_log);
    end
  endtask

  // result side: random stall, plus one long hold-off on request
  always @(posedge clk) begin
    if (hold_req && hold_cycles < 300) begin
      out_stall <= 1'b1;
      hold_cycles <= hold_cycles + 1;
    end else begin
      out_stall <= idle_on && ($urandom_range(0, 99) < 24);
    end
  end

  always @(posedge clk) begin
    bin_reading_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_reads.size() == 0) begin
        $error("bin read result with none expected");
        mismatch_count++;
      end else begin
        want = pending_reads.pop_front();
        reads_checked++;
        if (bin_count !== want.cnt) begin
          $error("bin_count expected %0d actual %0d", want.cnt, bin_count);
          mismatch_count++;
        end
        if (bin_distance_sum !== want.dsum) begin
          $error("bin_distance_sum expected %0d actual %0d", want.dsum, bin_distance_sum);
          mismatch_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet <= 0;
    else quiet <= quiet + 1;
    if (quiet >= QUIET_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    directed_row_t rows[$];
    pair_beat_t b;
    longint unsigned u;
    u = 64'd1 << 16;
    n_edges_reg = 6'd32;
    n_pi_reg = 6'd32;
    pi_cut_reg = 31'h7FFF_FFFF;
    inv_width_reg = 32'd65536;
    foreach (count_shadow[i]) begin
      count_shadow[i] = '0;
      dsum_shadow[i] = '0;
    end
    foreach (edge_sq_shadow[i]) edge_sq_shadow[i] = '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // reset configuration, edges at whole multiples of one unit
    load_edges(u, 1'b1);

    b = blank_beat(OP_READ);
    rows.push_back('{b, 1'b1, 32'd0, 63'd0});
    b.slot = 11'(BINS - 1);
    rows.push_back('{b, 1'b1, 32'd0, 63'd0});
    b.slot = 11'h7FF;
    rows.push_back('{b, 1'b1, 32'd0, 63'd0});
    b = blank_beat(OP_NONE);
    b.slot = 11'h7FF; b.edge_sq = 63'(MAX63);
    b.fx = 31'(MAX31); b.fy = 31'(MAX31); b.fz = 31'(MAX31);
    rows.push_back('{b, 1'b0, 32'd0, 63'd0});
    b.op = OP_LOAD_EDGE;
    rows.push_back('{b, 1'b0, 32'd0, 63'd0});
    b.slot = 11'(EDGES);
    rows.push_back('{b, 1'b0, 32'd0, 63'd0});
    b = blank_beat(OP_COUNT);
    rows.push_back('{b, 1'b0, 32'd0, 63'd0});
    b.sx = 31'(MAX31); b.sy = 31'(MAX31); b.sz = 31'(MAX31);
    rows.push_back('{b, 1'b0, 32'd0, 63'd0});
    b.fx = 31'(MAX31); b.fy = 31'(MAX31); b.fz = 31'(MAX31);
    rows.push_back('{b, 1'b0, 32'd0, 63'd0});
    b = blank_beat(OP_COUNT);
    b.fx = 31'd1000; b.sx = 31'(1000 + u);
    rows.push_back('{b, 1'b0, 32'd0, 63'd0});
    b.fx = '0; b.sx = 31'(31 * u);
    rows.push_back('{b, 1'b0, 32'd0, 63'd0});
    b.sx = 31'(31 * u - 1);
    rows.push_back('{b, 1'b0, 32'd0, 63'd0});
    b = blank_beat(OP_COUNT);
    b.sz = 31'(MAX31);
    rows.push_back('{b, 1'b0, 32'd0, 63'd0});
    b.sz = 31'(MAX31 - 1);
    rows.push_back('{b, 1'b0, 32'd0, 63'd0});
    foreach (rows[i]) send_beat(rows[i].beat, rows[i].typed, rows[i].cnt, rows[i].dsum);
    b = blank_beat(OP_READ);
    b.slot = 11'd0;   send_beat(b);
    b.slot = 11'd33;  send_beat(b);
    b.slot = 11'd990; send_beat(b);
    b.slot = 11'd32;  send_beat(b);

    run_phase(32, 32, MAX31, 65536, 18, 21, 1'b1, 1'b1, 250, 1'b0);
    run_phase(2, 1, 1 << 20, 32'hFFFF_FFFF, 16, 21, 1'b1, 1'b0, 250, 1'b0);
    run_phase(63, 63, MAX31, 1 << 12, 24, 30, 1'b0, 1'b1, 250, 1'b1);
    run_phase(0, 0, 0, 0, 20, 20, 1'b1, 1'b1, 150, 1'b0);
    run_phase(1, 17, 1 << 28, 1 << 10, 20, 28, 1'b1, 1'b1, 200, 1'b0);
    run_phase(20, 5, 1 << 22, 1 << 14, 12, 22, 1'b1, 1'b1, 200, 1'b0);
    wait_drained();

    $display("Sent %0d beats over six register settings: %0d pairs binned, %0d reads checked.",
             items_sent, pairs_binned, reads_checked);
    if (mismatch_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end
endmodule
`default_nettype wire

// ----- filelist.f -----
+incdir+hdl
hdl/pphist_pkg.sv
hdl/pphist_ram.sv
hdl/pphist_sqrt.sv
hdl/projected_pair_distance_histogram.sv
verif/testbench.sv
